FILE: design/rmt_pkg.sv
// Shared constants, codes and types of the ring membership table.
`default_nettype none
package rmt_pkg;

  localparam int MAX_MEMBERS_DEF = 32;
  localparam int SMALL_RING      = 5;
  localparam int NB_MAX          = 4;
  localparam int ID_W            = 32;
  localparam int TIME_W          = 64;
  localparam int SLACK_W         = 16;
  localparam int CMD_W           = 3;
  localparam int COUNT_W         = 6;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam logic [SLACK_W-1:0] SLACK_RESET = 16'd2000;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD       = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_HEARTBEAT = 3'd2,
    CMD_NEIGHBORS = 3'd3,
    CMD_SUCCESSOR = 3'd4,
    CMD_LOOKUP    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_ABSENT    = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLACK    = 2'd1;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CMP,
    S_ADD_POS, S_ADD_SH_RD, S_ADD_SH_WR, S_ADD_WR,
    S_RM_FOUND, S_RM_OLD_RD, S_RM_OLD_CAP, S_RM_HB_RD, S_RM_HB_CAP,
    S_RM_SH_RD, S_RM_SH_WR, S_RM_DEC, S_RM_NEW_RD, S_RM_NEW_CHK,
    S_RM_NEW_WR, S_RM_DONE, S_HB_DO, S_Q_RD, S_Q_CAP,
    S_NB_START, S_NBS_RD, S_NBS_CMP, S_NB_BIG,
    S_NB_EMIT, S_NBE_RD, S_NBE_CAP, S_EMIT
  } state_t;

  typedef struct packed {
    logic              load;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] hb;
    status_t           status;
    logic              last;
  } res_load_t;

endpackage
`default_nettype wire

FILE: design/rmt_cmd_if.sv
// Command channel carrying one table command per item.
`default_nettype none
interface rmt_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [rmt_pkg::CMD_W-1:0]  command;
  logic [rmt_pkg::ID_W-1:0]   member_id;
  logic [rmt_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, command, member_id, now_ms, input ready);
  modport sink (input valid, command, member_id, now_ms, output ready);
endinterface
`default_nettype wire

FILE: design/rmt_res_if.sv
// Result channel carrying one result item per handshake.
`default_nettype none
interface rmt_res_if;
  logic                        valid;
  logic                        ready;
  logic [rmt_pkg::ID_W-1:0]    result_id;
  logic [rmt_pkg::TIME_W-1:0]  result_heartbeat;
  logic [1:0]                  status;
  logic [rmt_pkg::COUNT_W-1:0] member_count;
  logic                        last;

  modport source (output valid, result_id, result_heartbeat, status, member_count, last,
                  input ready);
  modport sink (input valid, result_id, result_heartbeat, status, member_count, last,
                output ready);
endinterface
`default_nettype wire

FILE: design/rmt_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: design/rmt_ctrl.sv
// Command sequencer that scans, shifts and stamps the table memories.
`default_nettype none
module rmt_ctrl #(
  parameter int MAX_MEMBERS = rmt_pkg::MAX_MEMBERS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  rmt_cmd_if.sink                                   cmd,
  input  wire logic [rmt_pkg::ID_W-1:0]             local_id,
  input  wire logic [rmt_pkg::SLACK_W-1:0]          slack,
  input  wire logic                                 out_free,
  output rmt_pkg::res_load_t                        res_ld,
  output logic      [rmt_pkg::COUNT_W-1:0]          member_count,
  output logic      [$clog2(MAX_MEMBERS)-1:0]       rd_addr,
  input  wire logic [rmt_pkg::ID_W-1:0]             rd_id,
  input  wire logic [rmt_pkg::TIME_W-1:0]           rd_hb,
  output logic      [$clog2(MAX_MEMBERS)-1:0]       wr_addr,
  output logic                                      id_we,
  output logic                                      hb_we,
  output logic      [rmt_pkg::ID_W-1:0]             wr_id,
  output logic      [rmt_pkg::TIME_W-1:0]           wr_hb
);
  localparam int AW = $clog2(MAX_MEMBERS);
  localparam int CW = $clog2(MAX_MEMBERS + 1);

  rmt_pkg::state_t state, state_next, scan_ret, nb_ret, emit_ret;

  logic [CW-1:0]             count, idx, pos;
  logic [AW-1:0]             fidx, rm_idx;
  logic                      found, scan_gt, nb_local, nb_absent;
  logic [rmt_pkg::ID_W-1:0]  scan_key, tgt_id;
  logic [rmt_pkg::TIME_W-1:0] now;
  logic [rmt_pkg::CMD_W-1:0] cmd_code;
  logic [AW-1:0]             nb_idx [rmt_pkg::NB_MAX];
  logic [rmt_pkg::ID_W-1:0]  old_ids [rmt_pkg::NB_MAX];
  logic [2:0]                nb_n, n_old, k;
  logic [rmt_pkg::ID_W-1:0]  res_id;
  logic [rmt_pkg::TIME_W-1:0] res_hb;
  rmt_pkg::status_t          res_st;
  logic                      res_last;

  logic                      scan_hit, small_ring, seen, k_done;
  logic [2:0]                nb_cnt;
  logic [CW:0]               p_w, c_w, p1, p2;
  logic [AW-1:0]             big_idx [rmt_pkg::NB_MAX];
  logic [CW:0]               succ_w;
  logic [31:0]               count_wide;

  assign scan_hit   = scan_gt ? (rd_id > scan_key) : (rd_id == scan_key);
  assign small_ring = count <= CW'(rmt_pkg::SMALL_RING);
  assign nb_cnt     = nb_absent ? 3'd0 : nb_n;
  assign k_done     = (k == nb_cnt);
  assign cmd.ready  = (state == rmt_pkg::S_IDLE) && !rst;
  assign count_wide = 32'(count);
  assign member_count = count_wide[rmt_pkg::COUNT_W-1:0];

  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < rmt_pkg::NB_MAX; j++) begin
      if ((3'(j) < n_old) && (old_ids[j] == rd_id)) begin
        seen = 1'b1;
      end
    end
  end

  always_comb begin
    p_w = (CW+1)'(fidx);
    c_w = (CW+1)'(count);
    p1  = p_w + (CW+1)'(1);
    p2  = p_w + (CW+1)'(2);
    if (p_w >= (CW+1)'(2)) begin
      big_idx[0] = AW'(p_w - (CW+1)'(2));
      big_idx[1] = AW'(p_w - (CW+1)'(1));
    end else if (p_w == (CW+1)'(1)) begin
      big_idx[0] = '0;
      big_idx[1] = AW'(c_w - (CW+1)'(1));
    end else begin
      big_idx[0] = AW'(c_w - (CW+1)'(1));
      big_idx[1] = AW'(c_w - (CW+1)'(2));
    end
    big_idx[2] = (p1 < c_w) ? AW'(p1) : AW'(p1 - c_w);
    big_idx[3] = (p2 < c_w) ? AW'(p2) : AW'(p2 - c_w);
    succ_w = (p1 < c_w) ? p1 : '0;
  end

  always_comb begin
    state_next = state;
    case (state)
      rmt_pkg::S_IDLE:       if (cmd.valid) state_next = rmt_pkg::S_DISPATCH;
      rmt_pkg::S_DISPATCH: begin
        case (cmd_code)
          rmt_pkg::CMD_ADD:
            state_next = (count == CW'(MAX_MEMBERS)) ? rmt_pkg::S_EMIT : rmt_pkg::S_SCAN_RD;
          rmt_pkg::CMD_REMOVE, rmt_pkg::CMD_HEARTBEAT, rmt_pkg::CMD_SUCCESSOR,
          rmt_pkg::CMD_LOOKUP: state_next = rmt_pkg::S_SCAN_RD;
          rmt_pkg::CMD_NEIGHBORS: state_next = rmt_pkg::S_NB_START;
          default: state_next = rmt_pkg::S_EMIT;
        endcase
      end
      rmt_pkg::S_SCAN_RD:    state_next = (idx == count) ? scan_ret : rmt_pkg::S_SCAN_CMP;
      rmt_pkg::S_SCAN_CMP:   state_next = scan_hit ? scan_ret : rmt_pkg::S_SCAN_RD;
      rmt_pkg::S_ADD_POS:    state_next = rmt_pkg::S_ADD_SH_RD;
      rmt_pkg::S_ADD_SH_RD:  state_next = (idx == pos) ? rmt_pkg::S_ADD_WR : rmt_pkg::S_ADD_SH_WR;
      rmt_pkg::S_ADD_SH_WR:  state_next = rmt_pkg::S_ADD_SH_RD;
      rmt_pkg::S_ADD_WR:     state_next = rmt_pkg::S_EMIT;
      rmt_pkg::S_RM_FOUND:   state_next = found ? rmt_pkg::S_NB_START : rmt_pkg::S_EMIT;
      rmt_pkg::S_RM_OLD_RD:  state_next = k_done ? rmt_pkg::S_RM_HB_RD : rmt_pkg::S_RM_OLD_CAP;
      rmt_pkg::S_RM_OLD_CAP: state_next = rmt_pkg::S_RM_OLD_RD;
      rmt_pkg::S_RM_HB_RD:   state_next = rmt_pkg::S_RM_HB_CAP;
      rmt_pkg::S_RM_HB_CAP:  state_next = rmt_pkg::S_RM_SH_RD;
      rmt_pkg::S_RM_SH_RD:
        state_next = ((idx + CW'(1)) >= count) ? rmt_pkg::S_RM_DEC : rmt_pkg::S_RM_SH_WR;
      rmt_pkg::S_RM_SH_WR:   state_next = rmt_pkg::S_RM_SH_RD;
      rmt_pkg::S_RM_DEC:     state_next = rmt_pkg::S_NB_START;
      rmt_pkg::S_RM_NEW_RD:  state_next = k_done ? rmt_pkg::S_RM_DONE : rmt_pkg::S_RM_NEW_CHK;
      rmt_pkg::S_RM_NEW_CHK: state_next = seen ? rmt_pkg::S_RM_NEW_RD : rmt_pkg::S_SCAN_RD;
      rmt_pkg::S_RM_NEW_WR:  state_next = rmt_pkg::S_RM_NEW_RD;
      rmt_pkg::S_RM_DONE:    state_next = rmt_pkg::S_EMIT;
      rmt_pkg::S_HB_DO:      state_next = rmt_pkg::S_EMIT;
      rmt_pkg::S_Q_RD:       state_next = found ? rmt_pkg::S_Q_CAP : rmt_pkg::S_EMIT;
      rmt_pkg::S_Q_CAP:      state_next = rmt_pkg::S_EMIT;
      rmt_pkg::S_NB_START:   state_next = small_ring ? rmt_pkg::S_NBS_RD : rmt_pkg::S_SCAN_RD;
      rmt_pkg::S_NBS_RD:     state_next = (idx == count) ? nb_ret : rmt_pkg::S_NBS_CMP;
      rmt_pkg::S_NBS_CMP:    state_next = rmt_pkg::S_NBS_RD;
      rmt_pkg::S_NB_BIG:     state_next = nb_ret;
      rmt_pkg::S_NB_EMIT:
        state_next = (nb_absent || nb_n == 3'd0) ? rmt_pkg::S_EMIT : rmt_pkg::S_NBE_RD;
      rmt_pkg::S_NBE_RD:     state_next = rmt_pkg::S_NBE_CAP;
      rmt_pkg::S_NBE_CAP:    state_next = rmt_pkg::S_EMIT;
      rmt_pkg::S_EMIT:       if (out_free) state_next = emit_ret;
      default:               state_next = rmt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = '0;
    wr_addr = '0;
    id_we   = 1'b0;
    hb_we   = 1'b0;
    wr_id   = rd_id;
    wr_hb   = rd_hb;
    res_ld.load   = 1'b0;
    res_ld.id     = res_id;
    res_ld.hb     = res_hb;
    res_ld.status = res_st;
    res_ld.last   = res_last;
    case (state)
      rmt_pkg::S_SCAN_RD, rmt_pkg::S_NBS_RD: rd_addr = idx[AW-1:0];
      rmt_pkg::S_ADD_SH_RD: rd_addr = AW'(idx - CW'(1));
      rmt_pkg::S_ADD_SH_WR, rmt_pkg::S_RM_SH_WR: begin
        wr_addr = idx[AW-1:0];
        id_we   = 1'b1;
        hb_we   = 1'b1;
      end
      rmt_pkg::S_ADD_WR: begin
        wr_addr = pos[AW-1:0];
        id_we   = 1'b1;
        hb_we   = 1'b1;
        wr_id   = tgt_id;
        wr_hb   = now + rmt_pkg::TIME_W'(slack);
      end
      rmt_pkg::S_RM_OLD_RD, rmt_pkg::S_RM_NEW_RD, rmt_pkg::S_NBE_RD:
        rd_addr = nb_idx[k[1:0]];
      rmt_pkg::S_RM_HB_RD: rd_addr = rm_idx;
      rmt_pkg::S_RM_SH_RD: rd_addr = AW'(idx + CW'(1));
      rmt_pkg::S_RM_NEW_WR, rmt_pkg::S_HB_DO: begin
        wr_addr = fidx;
        hb_we   = found;
        wr_hb   = now;
      end
      rmt_pkg::S_Q_RD:
        rd_addr = (cmd_code == rmt_pkg::CMD_SUCCESSOR) ? AW'(succ_w) : fidx;
      rmt_pkg::S_EMIT: res_ld.load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmt_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        rmt_pkg::S_IDLE: begin
          cmd_code <= cmd.command;
          tgt_id   <= cmd.member_id;
          now      <= cmd.now_ms;
        end
        rmt_pkg::S_DISPATCH: begin
          idx      <= '0;
          scan_key <= tgt_id;
          scan_gt  <= (cmd_code == rmt_pkg::CMD_ADD);
          res_id   <= '0;
          res_hb   <= '0;
          res_st   <= rmt_pkg::ST_OK;
          res_last <= 1'b1;
          emit_ret <= rmt_pkg::S_IDLE;
          case (cmd_code)
            rmt_pkg::CMD_ADD: begin
              res_st   <= rmt_pkg::ST_FULL;
              scan_ret <= rmt_pkg::S_ADD_POS;
            end
            rmt_pkg::CMD_REMOVE:    scan_ret <= rmt_pkg::S_RM_FOUND;
            rmt_pkg::CMD_HEARTBEAT: scan_ret <= rmt_pkg::S_HB_DO;
            rmt_pkg::CMD_NEIGHBORS: nb_ret   <= rmt_pkg::S_NB_EMIT;
            default:                scan_ret <= rmt_pkg::S_Q_RD;
          endcase
        end
        rmt_pkg::S_SCAN_RD: begin
          if (idx == count) found <= 1'b0;
        end
        rmt_pkg::S_SCAN_CMP: begin
          if (scan_hit) begin
            found <= 1'b1;
            fidx  <= idx[AW-1:0];
          end else begin
            idx <= idx + CW'(1);
          end
        end
        rmt_pkg::S_ADD_POS: begin
          pos <= found ? CW'(fidx) : count;
          idx <= count;
        end
        rmt_pkg::S_ADD_SH_WR: idx <= idx - CW'(1);
        rmt_pkg::S_ADD_WR: begin
          count    <= count + CW'(1);
          res_id   <= tgt_id;
          res_hb   <= now + rmt_pkg::TIME_W'(slack);
          res_st   <= rmt_pkg::ST_OK;
        end
        rmt_pkg::S_RM_FOUND: begin
          rm_idx <= fidx;
          nb_ret <= rmt_pkg::S_RM_OLD_RD;
          if (!found) res_st <= rmt_pkg::ST_NOT_FOUND;
        end
        rmt_pkg::S_RM_OLD_RD: n_old <= nb_cnt;
        rmt_pkg::S_RM_OLD_CAP: begin
          old_ids[k[1:0]] <= rd_id;
          k <= k + 3'd1;
        end
        rmt_pkg::S_RM_HB_CAP: begin
          res_hb <= rd_hb;
          idx    <= CW'(rm_idx);
        end
        rmt_pkg::S_RM_SH_WR: idx <= idx + CW'(1);
        rmt_pkg::S_RM_DEC: begin
          count  <= count - CW'(1);
          nb_ret <= rmt_pkg::S_RM_NEW_RD;
        end
        rmt_pkg::S_RM_NEW_CHK: begin
          if (seen) begin
            k <= k + 3'd1;
          end else begin
            idx      <= '0;
            scan_key <= rd_id;
            scan_gt  <= 1'b0;
            scan_ret <= rmt_pkg::S_RM_NEW_WR;
          end
        end
        rmt_pkg::S_RM_NEW_WR: k <= k + 3'd1;
        rmt_pkg::S_RM_DONE: res_id <= tgt_id;
        rmt_pkg::S_HB_DO: begin
          if (found) begin
            res_id <= tgt_id;
            res_hb <= now;
          end else begin
            res_st <= rmt_pkg::ST_NOT_FOUND;
          end
        end
        rmt_pkg::S_Q_RD: begin
          if (!found) res_st <= rmt_pkg::ST_NOT_FOUND;
        end
        rmt_pkg::S_Q_CAP: begin
          res_id <= rd_id;
          res_hb <= rd_hb;
        end
        rmt_pkg::S_NB_START: begin
          k        <= '0;
          idx      <= '0;
          nb_n     <= '0;
          nb_local <= 1'b0;
          scan_key <= local_id;
          scan_gt  <= 1'b0;
          scan_ret <= rmt_pkg::S_NB_BIG;
        end
        rmt_pkg::S_NBS_RD: begin
          if (idx == count) nb_absent <= !nb_local;
        end
        rmt_pkg::S_NBS_CMP: begin
          if (rd_id == local_id) begin
            nb_local <= 1'b1;
          end else if (nb_n < 3'(rmt_pkg::NB_MAX)) begin
            nb_idx[nb_n[1:0]] <= idx[AW-1:0];
            nb_n <= nb_n + 3'd1;
          end
          idx <= idx + CW'(1);
        end
        rmt_pkg::S_NB_BIG: begin
          nb_absent <= !found;
          nb_n      <= 3'(rmt_pkg::NB_MAX);
          for (int j = 0; j < rmt_pkg::NB_MAX; j++) begin
            nb_idx[j] <= big_idx[j];
          end
        end
        rmt_pkg::S_NB_EMIT: begin
          if (nb_absent) res_st <= rmt_pkg::ST_ABSENT;
        end
        rmt_pkg::S_NBE_CAP: begin
          res_id   <= rd_id;
          res_hb   <= rd_hb;
          res_last <= (k + 3'd1 == nb_n);
          emit_ret <= (k + 3'd1 == nb_n) ? rmt_pkg::S_IDLE : rmt_pkg::S_NBE_RD;
          k        <= k + 3'd1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/ring_membership_table_top.sv
// Top level: configuration registers, table memories, sequencer and result register.
// One command is worked at a time; the next is accepted once the last result is
// registered. A scan reads and then compares each entry in turn, and a shift reads and
// then writes each moved entry, so the time of a command grows with the number of
// entries, plus any output stall, which holds the sequencer in its emit state.
// Reset clears the member count and restores the configuration; the memories keep content.
`default_nettype none
module ring_membership_table_top #(
  parameter int MAX_MEMBERS = rmt_pkg::MAX_MEMBERS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [rmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rmt_pkg::CFG_DATA_W-1:0]    cfg_data,
  rmt_cmd_if.sink                                cmd,
  rmt_res_if.source                              res
);
  localparam int AW = $clog2(MAX_MEMBERS);

  logic [rmt_pkg::ID_W-1:0]    local_id;
  logic [rmt_pkg::SLACK_W-1:0] slack;
  rmt_pkg::res_load_t          res_ld;
  logic [rmt_pkg::COUNT_W-1:0] count;
  logic                        out_free;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [rmt_pkg::ID_W-1:0]    rd_id, wr_id;
  logic [rmt_pkg::TIME_W-1:0]  rd_hb, wr_hb;
  logic                        id_we, hb_we;

  assign out_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_id <= '0;
      slack    <= rmt_pkg::SLACK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rmt_pkg::REG_LOCAL_ID: local_id <= cfg_data[rmt_pkg::ID_W-1:0];
        rmt_pkg::REG_SLACK:    slack    <= cfg_data[rmt_pkg::SLACK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_ld.load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (res_ld.load) begin
      res.result_id        <= res_ld.id;
      res.result_heartbeat <= res_ld.hb;
      res.status           <= res_ld.status;
      res.member_count     <= count;
      res.last             <= res_ld.last;
    end
  end

  rmt_ram #(.WIDTH(rmt_pkg::ID_W), .DEPTH(MAX_MEMBERS)) u_id_ram (
    .clk(clk), .we(id_we), .wr_addr(wr_addr), .wr_data(wr_id),
    .rd_addr(rd_addr), .rd_data(rd_id)
  );

  rmt_ram #(.WIDTH(rmt_pkg::TIME_W), .DEPTH(MAX_MEMBERS)) u_hb_ram (
    .clk(clk), .we(hb_we), .wr_addr(wr_addr), .wr_data(wr_hb),
    .rd_addr(rd_addr), .rd_data(rd_hb)
  );

  rmt_ctrl #(.MAX_MEMBERS(MAX_MEMBERS)) u_ctrl (
    .clk(clk), .rst(rst), .cmd(cmd), .local_id(local_id), .slack(slack),
    .out_free(out_free), .res_ld(res_ld), .member_count(count),
    .rd_addr(rd_addr), .rd_id(rd_id), .rd_hb(rd_hb), .wr_addr(wr_addr),
    .id_we(id_we), .hb_we(hb_we), .wr_id(wr_id), .wr_hb(wr_hb)
  );
endmodule
`default_nettype wire

FILE: bench/ring_membership_table_top_tb.sv
// Self-checking testbench of the ring membership table: directed and random commands
// against a built-in table predictor, with random stalls on both channels.
`timescale 1ns / 100ps
`default_nettype none
module ring_membership_table_top_tb;

  typedef struct packed {
    logic [rmt_pkg::ID_W-1:0]    id;
    logic [rmt_pkg::TIME_W-1:0]  hb;
    logic [1:0]                  status;
    logic [rmt_pkg::COUNT_W-1:0] count;
    logic                        last;
  } answer_t;

  localparam int TBL = rmt_pkg::MAX_MEMBERS_DEF;
  localparam logic [rmt_pkg::CMD_W-1:0] CMD_BAD6 = 3'd6;
  localparam logic [rmt_pkg::CMD_W-1:0] CMD_BAD7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rmt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rmt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  rmt_cmd_if cmd_ch ();
  rmt_res_if res_ch ();

  ring_membership_table_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd_ch.sink), .res(res_ch.source)
  );

  logic [rmt_pkg::ID_W-1:0] tbl_id [TBL];
  logic [rmt_pkg::TIME_W-1:0] tbl_hb [TBL];
  int tbl_n = 0;
  logic [rmt_pkg::ID_W-1:0] my_id = '0;
  logic [rmt_pkg::SLACK_W-1:0] my_slack = rmt_pkg::SLACK_RESET;

  answer_t pending_answers[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  longint cycles = 0;

  initial forever #10 clk = ~clk;

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.command = '0;
    cmd_ch.member_id = '0;
    cmd_ch.now_ms = '0;
    res_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd1500000) begin
      $display("ring_membership_table_top_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = {res_ch.result_id, res_ch.result_heartbeat, res_ch.status,
             res_ch.member_count, res_ch.last};
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected id %h hb %h st %0d n %0d last %0b, ",
                      "got id %h hb %h st %0d n %0d last %0b"},
                     want.id, want.hb, want.status, want.count, want.last,
                     got.id, got.hb, got.status, got.count, got.last);
        end
      end
    end
  end

  function automatic int first_index(logic [rmt_pkg::ID_W-1:0] id);
    for (int i = 0; i < tbl_n; i++) if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int ring_neighbors(output int nb[4]);
    int u, n;
    u = first_index(my_id);
    n = 0;
    if (u < 0) return -1;
    if (tbl_n <= rmt_pkg::SMALL_RING) begin
      for (int i = 0; i < tbl_n; i++)
        if (tbl_id[i] != my_id && n < 4) begin
          nb[n] = i;
          n++;
        end
      return n;
    end
    if (u >= 2) begin
      nb[0] = u - 2; nb[1] = u - 1;
    end else if (u == 1) begin
      nb[0] = 0; nb[1] = tbl_n - 1;
    end else begin
      nb[0] = tbl_n - 1; nb[1] = tbl_n - 2;
    end
    nb[2] = (u + 1 < tbl_n) ? u + 1 : u + 1 - tbl_n;
    nb[3] = (u + 2 < tbl_n) ? u + 2 : u + 2 - tbl_n;
    return 4;
  endfunction

  task automatic expect_answer(logic [rmt_pkg::ID_W-1:0] id, logic [rmt_pkg::TIME_W-1:0] hb,
                               rmt_pkg::status_t st, logic last);
    answer_t a;
    a = {id, hb, st, tbl_n[rmt_pkg::COUNT_W-1:0], last};
    pending_answers = {pending_answers, a};
  endtask

  task automatic predict_table(logic [rmt_pkg::CMD_W-1:0] op, logic [rmt_pkg::ID_W-1:0] id,
                               logic [rmt_pkg::TIME_W-1:0] now);
    int f, pos, n, n_old;
    int nb[4];
    logic [rmt_pkg::ID_W-1:0] old_ids[4];
    logic [rmt_pkg::TIME_W-1:0] old_hb;
    bit seen;
    case (op)
      rmt_pkg::CMD_ADD: begin
        if (tbl_n >= TBL) begin
          expect_answer('0, '0, rmt_pkg::ST_FULL, 1'b1);
        end else begin
          pos = 0;
          while (pos < tbl_n && tbl_id[pos] <= id) pos++;
          for (int i = tbl_n; i > pos; i--) begin
            tbl_id[i] = tbl_id[i-1];
            tbl_hb[i] = tbl_hb[i-1];
          end
          tbl_id[pos] = id;
          tbl_hb[pos] = now + rmt_pkg::TIME_W'(my_slack);
          tbl_n++;
          expect_answer(id, tbl_hb[pos], rmt_pkg::ST_OK, 1'b1);
        end
      end
      rmt_pkg::CMD_REMOVE: begin
        f = first_index(id);
        if (f < 0) begin
          expect_answer('0, '0, rmt_pkg::ST_NOT_FOUND, 1'b1);
        end else begin
          n_old = ring_neighbors(nb);
          if (n_old < 0) n_old = 0;
          for (int k = 0; k < n_old; k++) old_ids[k] = tbl_id[nb[k]];
          old_hb = tbl_hb[f];
          for (int i = f; i + 1 < tbl_n; i++) begin
            tbl_id[i] = tbl_id[i+1];
            tbl_hb[i] = tbl_hb[i+1];
          end
          tbl_n--;
          n = ring_neighbors(nb);
          for (int k = 0; k < n; k++) begin
            seen = 0;
            for (int j = 0; j < n_old; j++) if (old_ids[j] == tbl_id[nb[k]]) seen = 1;
            if (!seen) tbl_hb[first_index(tbl_id[nb[k]])] = now;
          end
          expect_answer(id, old_hb, rmt_pkg::ST_OK, 1'b1);
        end
      end
      rmt_pkg::CMD_HEARTBEAT: begin
        f = first_index(id);
        if (f < 0) begin
          expect_answer('0, '0, rmt_pkg::ST_NOT_FOUND, 1'b1);
        end else begin
          tbl_hb[f] = now;
          expect_answer(id, now, rmt_pkg::ST_OK, 1'b1);
        end
      end
      rmt_pkg::CMD_NEIGHBORS: begin
        n = ring_neighbors(nb);
        if (n < 0) expect_answer('0, '0, rmt_pkg::ST_ABSENT, 1'b1);
        else if (n == 0) expect_answer('0, '0, rmt_pkg::ST_OK, 1'b1);
        else
          for (int k = 0; k < n; k++)
            expect_answer(tbl_id[nb[k]], tbl_hb[nb[k]], rmt_pkg::ST_OK, k == n - 1);
      end
      rmt_pkg::CMD_SUCCESSOR, rmt_pkg::CMD_LOOKUP: begin
        f = first_index(id);
        if (f < 0) begin
          expect_answer('0, '0, rmt_pkg::ST_NOT_FOUND, 1'b1);
        end else begin
          if (op == rmt_pkg::CMD_SUCCESSOR) f = (f + 1 < tbl_n) ? f + 1 : 0;
          expect_answer(tbl_id[f], tbl_hb[f], rmt_pkg::ST_OK, 1'b1);
        end
      end
      default: expect_answer('0, '0, rmt_pkg::ST_OK, 1'b1);
    endcase
  endtask

  task automatic send_command(logic [rmt_pkg::CMD_W-1:0] op, logic [rmt_pkg::ID_W-1:0] id,
                              logic [rmt_pkg::TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= op;
    cmd_ch.member_id <= id;
    cmd_ch.now_ms <= now;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predict_table(op, id, now);
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_register(logic [rmt_pkg::CFG_IDX_W-1:0] idx,
                                logic [rmt_pkg::CFG_DATA_W-1:0] val);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rmt_pkg::REG_LOCAL_ID) my_id = val;
    else my_slack = val[rmt_pkg::SLACK_W-1:0];
  endtask

  function automatic logic [rmt_pkg::ID_W-1:0] pick_id();
    if (tbl_n > 0 && $urandom_range(2) != 0) return tbl_id[$urandom_range(tbl_n - 1)];
    return $urandom_range(3) == 0 ? $urandom() : rmt_pkg::ID_W'($urandom_range(40));
  endfunction

  function automatic logic [rmt_pkg::TIME_W-1:0] pick_time();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_directed();
    send_command(rmt_pkg::CMD_NEIGHBORS, 0, 0);
    send_command(rmt_pkg::CMD_LOOKUP, 5, 0);
    send_command(rmt_pkg::CMD_ADD, 0, '1);
    send_command(rmt_pkg::CMD_NEIGHBORS, 0, 1);
    send_command(rmt_pkg::CMD_ADD, '1, 64'h0);
    send_command(rmt_pkg::CMD_ADD, 7, 64'h5555_5555_5555_5555);
    send_command(rmt_pkg::CMD_ADD, 7, 64'hAAAA_AAAA_AAAA_AAAA);
    send_command(rmt_pkg::CMD_NEIGHBORS, 0, 1);
    send_command(rmt_pkg::CMD_SUCCESSOR, '1, 2);
    send_command(rmt_pkg::CMD_HEARTBEAT, 7, 99);
    send_command(rmt_pkg::CMD_HEARTBEAT, 8, 99);
    send_command(rmt_pkg::CMD_REMOVE, 9, 3);
    send_command(CMD_BAD6, 7, 4);
    send_command(CMD_BAD7, 7, 4);
    for (int i = 0; i < 4; i++) send_command(rmt_pkg::CMD_ADD, 10 + i, 1000 + i);
    send_command(rmt_pkg::CMD_NEIGHBORS, 0, 5);
    send_command(rmt_pkg::CMD_REMOVE, 7, 6);
    send_command(rmt_pkg::CMD_NEIGHBORS, 0, 7);
    send_command(rmt_pkg::CMD_REMOVE, 0, 8);
    send_command(rmt_pkg::CMD_NEIGHBORS, 0, 9);
    send_command(rmt_pkg::CMD_LOOKUP, '1, 10);
  endtask

  task automatic test_full_table();
    while (tbl_n < TBL) send_command(rmt_pkg::CMD_ADD, $urandom_range(60), pick_time());
    send_command(rmt_pkg::CMD_ADD, 3, 5);
    send_command(rmt_pkg::CMD_NEIGHBORS, 0, 6);
    while (tbl_n > 4)
      send_command(rmt_pkg::CMD_REMOVE, tbl_id[$urandom_range(tbl_n - 1)], pick_time());
  endtask

  task automatic test_random(int count);
    int r;
    logic [rmt_pkg::CMD_W-1:0] op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 30 && tbl_n < TBL) op = rmt_pkg::CMD_ADD;
      else if (r < 45) op = rmt_pkg::CMD_REMOVE;
      else if (r < 58) op = rmt_pkg::CMD_HEARTBEAT;
      else if (r < 78) op = rmt_pkg::CMD_NEIGHBORS;
      else if (r < 87) op = rmt_pkg::CMD_SUCCESSOR;
      else if (r < 97) op = rmt_pkg::CMD_LOOKUP;
      else op = rmt_pkg::CMD_W'($urandom_range(6, 7));
      if (op == rmt_pkg::CMD_ADD && tbl_n < 8 && $urandom_range(3) == 0)
        send_command(op, my_id, pick_time());
      else send_command(op, pick_id(), pick_time());
      if (i == count / 2) drain_results();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 33;
    recv_idle_pct = 65;
    test_directed();
    write_register(rmt_pkg::REG_SLACK, 16'hFFFF);
    write_register(rmt_pkg::REG_LOCAL_ID, 32'd12);
    test_random(25);
    send_idle_pct = 65;
    recv_idle_pct = 33;
    test_full_table();
    write_register(rmt_pkg::REG_LOCAL_ID, 32'hFFFF_FFFF);
    write_register(rmt_pkg::REG_SLACK, 16'd0);
    send_command(rmt_pkg::CMD_ADD, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    test_random(25);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(rmt_pkg::REG_LOCAL_ID, 32'd20);
    write_register(rmt_pkg::REG_SLACK, 16'd1234);
    send_command(rmt_pkg::CMD_ADD, 20, 77);
    test_random(25);
    drain_results();
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("ring_membership_table_top_tb OK");
    end else begin
      $display("ring_membership_table_top_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
